// ----- sv/cruise_mode_pi_controller_macros.svh -----
// assertion macros for the cruise mode pi controller
// no dependencies, included by cmpi_ctrl, which checks its own logic
`ifndef CRUISE_MODE_PI_CONTROLLER_MACROS_SVH
`define CRUISE_MODE_PI_CONTROLLER_MACROS_SVH

// same-cycle implication
`define CMPI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CMPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/cmpi_pkg.sv -----
// shared types, widths and constants of the cruise mode pi controller
// no dependencies
package cmpi_pkg;

   localparam int LOOP_MS       = 20;
   localparam int ERROR_HOLD_MS = 2000;
   localparam int AVG_TAPS      = 4;

   localparam int SUM_W = 16 + $clog2(AVG_TAPS);

   // integral step: err * 256 * LOOP_MS / 1000 via reciprocal multiply
   localparam int INTEG_NUM = 256 * LOOP_MS;
   localparam int INTEG_DEN = 1000;
   localparam int SCL_W     = 16 + $clog2(INTEG_NUM + 1);
   localparam int RECIP_SH  = 40;
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + INTEG_DEN - 1) / INTEG_DEN;
   localparam int RECIP_W   = 31;
   localparam int DPROD_W   = SCL_W + RECIP_W;
   localparam int DELTA_W   = DPROD_W - RECIP_SH;

   localparam int INTEG_W = 24;
   localparam int ISUM_W  = INTEG_W + 2;
   localparam int ERR_W   = 17;
   localparam int PPROD_W = ERR_W + 17;
   localparam int IPROD_W = INTEG_W + 16;
   localparam int ACC_W   = IPROD_W + 3;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [15:0] SP_STEP = 16'd256;

   localparam logic [15:0] RST_MIN_SPEED    = 16'd10240;
   localparam logic [15:0] RST_DECEL_THR    = 16'hFB33;
   localparam logic [15:0] RST_PROP_GAIN    = 16'd2560;
   localparam logic [15:0] RST_INTEG_GAIN   = 16'd256;
   localparam logic [23:0] RST_INTEGRAL_MAX = 24'd1310720;
   localparam logic [15:0] RST_THROTTLE_MAX = 16'd25600;
   localparam logic [15:0] RST_WAKE_TIME    = 16'd3000;
   localparam logic [15:0] RST_ABORT_TIME   = 16'd2000;

   typedef enum logic [2:0] {
      MODE_OFF    = 3'd0,
      MODE_IDLE   = 3'd1,
      MODE_WAKE   = 3'd2,
      MODE_WAIT   = 3'd3,
      MODE_READY  = 3'd4,
      MODE_ACTIVE = 3'd5,
      MODE_ABORT  = 3'd6,
      MODE_ERROR  = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_PREP  = 3'd1,
      ST_MUL1  = 3'd2,
      ST_INTEG = 3'd3,
      ST_MUL2  = 3'd4,
      ST_FIN   = 3'd5
   } step_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_SPEED    = 4'd0,
      REG_DECEL_THR    = 4'd1,
      REG_PROP_GAIN    = 4'd2,
      REG_INTEG_GAIN   = 4'd3,
      REG_INTEGRAL_MAX = 4'd4,
      REG_THROTTLE_MAX = 4'd5,
      REG_WAKE_TIME    = 4'd6,
      REG_ABORT_TIME   = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul1;
      logic integ;
      logic mul2;
      logic fin;
   } cmd_type;

endpackage

// ----- sv/cmpi_if.sv -----
// channel interfaces: tick input, result output and register write
// depends on cmpi_pkg
interface cmpi_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        now_ms;
   logic [15:0]        speed;
   logic [15:0]        drv_throttle;
   logic signed [15:0] accel_z;
   logic               fault;
   logic               e_stop;
   logic               btn_cancel;
   logic               btn_down;
   logic               btn_up;

   modport source (output valid, now_ms, speed, drv_throttle, accel_z, fault, e_stop,
                   btn_cancel, btn_down, btn_up, input ready);
   modport sink (input valid, now_ms, speed, drv_throttle, accel_z, fault, e_stop,
                 btn_cancel, btn_down, btn_up, output ready);
endinterface

interface cmpi_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] thr_cmd;
   logic [2:0]  mode_code;
   logic [15:0] target_speed;

   modport source (output valid, thr_cmd, mode_code, target_speed, input ready);
   modport sink (input valid, thr_cmd, mode_code, target_speed, output ready);
endinterface

interface cmpi_csr_if;
   import cmpi_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/cmpi_datapath.sv -----
// datapath: registers, accel history, mode register, set speed and pi arithmetic
// depends on cmpi_pkg, stepped by cmpi_ctrl through cmd_type
module cmpi_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cmpi_pkg::cmd_type              cmd,
   input  logic                           csr_we,
   input  logic [cmpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cmpi_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic [31:0]                    now_ms,
   input  logic [15:0]                    speed,
   input  logic [15:0]                    drv_throttle,
   input  logic signed [15:0]             accel_z,
   input  logic                           fault,
   input  logic                           e_stop,
   input  logic                           btn_cancel,
   input  logic                           btn_down,
   input  logic                           btn_up,
   output logic [15:0]                    thr_cmd,
   output logic [2:0]                     mode_code,
   output logic [15:0]                    target_speed
);
   import cmpi_pkg::*;

   localparam logic signed [SUM_W-1:0] TAPS_S = SUM_W'(AVG_TAPS);

   logic [15:0]         min_speed_ff, prop_gain_ff, integ_gain_ff, throttle_max_ff;
   logic signed [15:0]  decel_thr_ff;
   logic [23:0]         integral_max_ff;
   logic [15:0]         wake_time_ff, abort_time_ff;

   logic [31:0]         now_ff;
   logic [15:0]         speed_ff, thr_in_ff;
   logic                fault_ff, e_stop_ff, cancel_ff, down_ff, up_ff;
   logic signed [15:0]  hist_ff [AVG_TAPS];

   mode_type            mode_ff, mode_next;
   logic [15:0]         set_point_ff;
   logic [INTEG_W-1:0]  err_integral_ff;
   logic [31:0]         entered_at_ff;

   logic                ready_ff, abort_ff, wake_exp_ff, abort_exp_ff, hold_exp_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic                      err_neg_ff;
   logic [SCL_W-1:0]          abs_scl_ff;
   logic [DPROD_W-1:0]        dprod_ff;
   logic signed [PPROD_W-1:0] pprod_ff;
   logic [IPROD_W-1:0]        iprod_ff;

   logic [15:0]         rsp_throttle_ff, rsp_target_ff;
   logic [2:0]          rsp_mode_ff;

   logic signed [SUM_W-1:0]   sum_c, thr_scaled_c;
   logic [16:0]               sp_up_sum_c;
   logic [15:0]               sp_a_c, sp_b_c, sp_new_c, abs_c;
   logic signed [ERR_W-1:0]   err_c;
   logic [31:0]               elapsed_c;
   logic signed [ISUM_W-1:0]  delta_c, isum_c;
   logic [INTEG_W-1:0]        integ_c;
   logic signed [ACC_W-1:0]   acc_c;
   logic [ACC_W-18:0]         q_c;
   logic [15:0]               thr_c;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_ff    <= RST_MIN_SPEED;
         decel_thr_ff    <= RST_DECEL_THR;
         prop_gain_ff    <= RST_PROP_GAIN;
         integ_gain_ff   <= RST_INTEG_GAIN;
         integral_max_ff <= RST_INTEGRAL_MAX;
         throttle_max_ff <= RST_THROTTLE_MAX;
         wake_time_ff    <= RST_WAKE_TIME;
         abort_time_ff   <= RST_ABORT_TIME;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MIN_SPEED:    min_speed_ff    <= csr_data[15:0];
            REG_DECEL_THR:    decel_thr_ff    <= csr_data[15:0];
            REG_PROP_GAIN:    prop_gain_ff    <= csr_data[15:0];
            REG_INTEG_GAIN:   integ_gain_ff   <= csr_data[15:0];
            REG_INTEGRAL_MAX: integral_max_ff <= csr_data[23:0];
            REG_THROTTLE_MAX: throttle_max_ff <= csr_data[15:0];
            REG_WAKE_TIME:    wake_time_ff    <= csr_data[15:0];
            REG_ABORT_TIME:   abort_time_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // tick capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff    <= now_ms;
         speed_ff  <= speed;
         thr_in_ff <= drv_throttle;
         fault_ff  <= fault;
         e_stop_ff <= e_stop;
         cancel_ff <= btn_cancel;
         down_ff   <= btn_down;
         up_ff     <= btn_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         hist_ff[0] <= accel_z;
         for (int i = 1; i < AVG_TAPS; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   // prep: flags, set speed, error
   always_comb begin
      sum_c = '0;
      for (int i = 0; i < AVG_TAPS; i++) begin
         sum_c = sum_c + SUM_W'(hist_ff[i]);
      end
      thr_scaled_c = SUM_W'(decel_thr_ff) * TAPS_S;
      sp_up_sum_c  = {1'b0, set_point_ff} + {1'b0, SP_STEP};
      sp_a_c = up_ff ? (sp_up_sum_c[16] ? 16'hFFFF : sp_up_sum_c[15:0]) : set_point_ff;
      sp_b_c = down_ff ? ((sp_a_c < SP_STEP) ? 16'd0 : sp_a_c - SP_STEP) : sp_a_c;
      sp_new_c  = (mode_ff == MODE_ACTIVE) ? sp_b_c : speed_ff;
      err_c     = $signed({1'b0, sp_new_c}) - $signed({1'b0, speed_ff});
      abs_c     = err_c[ERR_W-1] ? 16'(-err_c) : err_c[15:0];
      elapsed_c = now_ff - entered_at_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         ready_ff     <= (speed_ff >= min_speed_ff);
         abort_ff     <= (sum_c < thr_scaled_c) || (speed_ff < min_speed_ff);
         wake_exp_ff  <= (elapsed_c > 32'(wake_time_ff));
         abort_exp_ff <= (elapsed_c > 32'(abort_time_ff));
         hold_exp_ff  <= (elapsed_c > 32'(ERROR_HOLD_MS));
         err_ff       <= err_c;
         err_neg_ff   <= err_c[ERR_W-1];
         abs_scl_ff   <= SCL_W'(abs_c) * SCL_W'(INTEG_NUM);
      end
      if (cmd.mul1) begin
         dprod_ff <= DPROD_W'(abs_scl_ff) * DPROD_W'(RECIP);
         pprod_ff <= PPROD_W'(err_ff) * $signed({{(PPROD_W-16){1'b0}}, prop_gain_ff});
      end
      if (cmd.mul2) begin
         iprod_ff <= IPROD_W'(err_integral_ff) * IPROD_W'(integ_gain_ff);
      end
   end

   // integral step and clamp
   always_comb begin
      delta_c = $signed(ISUM_W'(dprod_ff[RECIP_SH +: DELTA_W]));
      if (err_neg_ff) begin
         delta_c = -delta_c;
      end
      isum_c = $signed({2'b00, err_integral_ff}) + delta_c;
      if (isum_c < 0) begin
         integ_c = '0;
      end else if (isum_c > $signed({2'b00, integral_max_ff})) begin
         integ_c = integral_max_ff;
      end else begin
         integ_c = isum_c[INTEG_W-1:0];
      end
   end

   // throttle
   always_comb begin
      acc_c = (ACC_W'(pprod_ff) <<< 8) + $signed({3'b000, iprod_ff});
      q_c   = acc_c[ACC_W-2:16];
      if (mode_ff != MODE_ACTIVE) begin
         thr_c = thr_in_ff;
      end else if (acc_c[ACC_W-1] || (acc_c == '0)) begin
         thr_c = '0;
      end else if (q_c > (ACC_W-17)'(throttle_max_ff)) begin
         thr_c = throttle_max_ff;
      end else begin
         thr_c = q_c[15:0];
      end
   end

   // mode transitions
   always_comb begin
      mode_next = mode_ff;
      if (e_stop_ff) begin
         mode_next = MODE_OFF;
      end else begin
         unique case (mode_ff)
            MODE_OFF: mode_next = MODE_IDLE;
            MODE_IDLE: begin
               if (cancel_ff || down_ff || up_ff) mode_next = MODE_WAKE;
            end
            MODE_WAKE: begin
               if (cancel_ff) mode_next = MODE_IDLE;
               else if (wake_exp_ff) mode_next = MODE_WAIT;
            end
            MODE_WAIT: begin
               if (cancel_ff) mode_next = MODE_IDLE;
               else if (ready_ff) mode_next = MODE_READY;
            end
            MODE_READY: begin
               if (cancel_ff) mode_next = MODE_IDLE;
               else if (!ready_ff) mode_next = MODE_WAIT;
               else if (up_ff) mode_next = MODE_ACTIVE;
            end
            MODE_ACTIVE: begin
               if (fault_ff) mode_next = MODE_ERROR;
               else if (cancel_ff) mode_next = MODE_WAIT;
               else if (abort_ff) mode_next = MODE_ABORT;
            end
            MODE_ABORT: begin
               if (abort_exp_ff) mode_next = MODE_WAIT;
            end
            MODE_ERROR: begin
               if (hold_exp_ff && cancel_ff) mode_next = MODE_IDLE;
            end
            default: mode_next = MODE_OFF;
         endcase
      end
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_OFF;
         set_point_ff    <= '0;
         err_integral_ff <= '0;
         entered_at_ff   <= '0;
      end else begin
         if (cmd.prep) begin
            set_point_ff <= sp_new_c;
         end
         if (cmd.integ) begin
            err_integral_ff <= (mode_ff == MODE_ACTIVE) ? integ_c : '0;
         end
         if (cmd.fin) begin
            mode_ff <= mode_next;
            if (mode_next != mode_ff) begin
               entered_at_ff <= now_ff;
            end
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_throttle_ff <= thr_c;
         rsp_mode_ff     <= mode_next;
         rsp_target_ff   <= set_point_ff;
      end
   end

   assign thr_cmd      = rsp_throttle_ff;
   assign mode_code    = rsp_mode_ff;
   assign target_speed = rsp_target_ff;

endmodule

// ----- sv/cmpi_ctrl.sv -----
// sequencer: input handshake, datapath steps and result valid
// depends on cmpi_pkg and cruise_mode_pi_controller_macros.svh
module cmpi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cmpi_pkg::cmd_type cmd
);
   import cmpi_pkg::*;

   `include "cruise_mode_pi_controller_macros.svh"

   step_type step_ff, step_in;
   logic     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (step_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            step_in  = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.integ = 1'b1;
            step_in   = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            step_in  = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.fin = 1'b1;
               step_in = ST_IDLE;
            end
         end
         default: step_in = ST_IDLE;
      endcase

      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `CMPI_ASSERT_NOW(a_cmd_onehot, clock, reset, 1'b1, $onehot0({cmd.load, cmd.prep, cmd.mul1, cmd.integ, cmd.mul2, cmd.fin}), "datapath commands overlap")
   `CMPI_ASSERT_NEXT(a_load_then_prep, clock, reset, cmd.load, cmd.prep, "prep step missing after load")
   `CMPI_ASSERT_NEXT(a_mul2_then_fin, clock, reset, cmd.mul2, step_ff == ST_FIN, "finish step missing after second multiply")
   `CMPI_ASSERT_NOW(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(cmd.fin), "result word without finish step")

endmodule

// ----- sv/cruise_mode_pi_controller.sv -----
// top level of the cruise mode pi controller: sequencer plus datapath
// depends on cmpi_pkg, cmpi_if, cmpi_ctrl and cmpi_datapath
//
//   channel  dir  handshake     word
//   req_ch   in   valid/ready   one control tick: time, speed, throttle, accel, flags, buttons
//   rsp_ch   out  valid/ready   thr_cmd, mode_code, target_speed
//   csr_ch   in   valid/ready   register index and data, always ready
//
// one tick runs through accept, then prep, two multiplier steps with the clamp between,
// and finish; the chain of prop/integral multiplies through one shared sequence sets these steps
// reset is synchronous and returns registers, mode, set speed, integral and history to defaults
// a finished word waits in the output register; the finish step stalls only while it is full
module cruise_mode_pi_controller (
   input  logic        clock,
   input  logic        reset,
   cmpi_req_if.sink    req_ch,
   cmpi_rsp_if.source  rsp_ch,
   cmpi_csr_if.sink    csr_ch
);
   import cmpi_pkg::*;

   cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   cmpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   cmpi_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .csr_we       (csr_ch.valid),
      .csr_index    (csr_ch.index),
      .csr_data     (csr_ch.data),
      .now_ms       (req_ch.now_ms),
      .speed        (req_ch.speed),
      .drv_throttle (req_ch.drv_throttle),
      .accel_z      (req_ch.accel_z),
      .fault        (req_ch.fault),
      .e_stop       (req_ch.e_stop),
      .btn_cancel   (req_ch.btn_cancel),
      .btn_down     (req_ch.btn_down),
      .btn_up       (req_ch.btn_up),
      .thr_cmd      (rsp_ch.thr_cmd),
      .mode_code    (rsp_ch.mode_code),
      .target_speed (rsp_ch.target_speed)
   );

endmodule
